// ----- sv/tdtq_pkg.sv -----
// Shared types and constants of the tickless deadline timer queue.
package tdtq_pkg;
	localparam int TABLE_DEPTH_DEF = 16;
	localparam int ID_WIDTH_DEF    = 8;
	localparam logic [31:0] QUANTUM_RST = 32'd10000000;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_IRQ    = 2'd1,
		ACT_ARM    = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		KIND_WOKEN = 3'd0,
		KIND_ARM   = 3'd1,
		KIND_RESCH = 3'd2,
		KIND_ACK   = 3'd3,
		KIND_FULL  = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INS,
		CELL_POP
	} cell_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISP,
		ST_WAKE,
		ST_ARM,
		ST_DELTA,
		ST_MIN,
		ST_MAX
	} state_t;

	localparam logic [1:0] REG_ENABLE  = 2'd0;
	localparam logic [1:0] REG_QUANTUM = 2'd1;
	localparam logic [1:0] REG_MIN     = 2'd2;
	localparam logic [1:0] REG_MAX     = 2'd3;
endpackage

// ----- sv/tickless_deadline_timer_queue_core.sv -----
// Top level of the tickless deadline timer queue: wait chain, sequencer, APB registers.
// Sequence: each transaction is dispatched first; insert, ack and unknown action answer there,
// a remainder re-arm passes the minimum and maximum clamps, and an interrupt pops one expired
// wait per result, then may arm a delta through the arm, delta, minimum and maximum states.
// Throughput: one transaction at a time; the next is taken once the last result is registered.
// Reset: arst_n clears the entry count, programmed and quantum deadlines, the registers
// (quantum back to 10 ms) and the output valid; the chain cells are not cleared.
module tickless_deadline_timer_queue_core import tdtq_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int ID_WIDTH    = ID_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// APB-style configuration
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [63:0]         pwdata,
	output logic [63:0]         prdata,
	output logic                pready,
	// input channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          action,
	input  logic [63:0]         now_ns,
	input  logic [63:0]         deadline_ns,
	input  logic [ID_WIDTH-1:0] wait_id,
	input  logic                thread_is_idle,
	input  logic                ready_waiting,
	// result channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic [2:0]          kind,
	output logic [ID_WIDTH-1:0] woken_id,
	output logic [63:0]         delta_ns,
	output logic                preempt,
	output logic                last
);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_DEPTH);

	// configuration registers
	logic        en_q;
	logic [31:0] quantum_q, min_q;
	logic [47:0] max_q;

	// latched transaction
	action_t             act_q;
	logic [63:0]         now_q, dl_q;
	logic [ID_WIDTH-1:0] wid_q;
	logic                idle_q, ready_q;

	state_t      state_q, state_d;
	logic [CW-1:0] count_q;
	logic [63:0] pd_q, qd_q, tgt_q, dlt_q;

	// output register
	logic                out_valid_q;
	kind_t               kind_q;
	logic [ID_WIDTH-1:0] woken_q;
	logic [63:0]         delta_q;
	logic                pre_q, last_q;

	// sequencer actions
	logic                emit, e_pre, e_last;
	kind_t               e_kind;
	logic [ID_WIDTH-1:0] e_id;
	logic [63:0]         e_delta;
	cell_op_t            op;

	// chain
	logic [63:0]         c_dl   [TABLE_DEPTH];
	logic [ID_WIDTH-1:0] c_id   [TABLE_DEPTH];
	logic                c_keep [TABLE_DEPTH];

	logic in_acc, can_emit, full, head_exp, pd_future;
	logic [64:0] qsum;
	logic [63:0] qsat, arm_tgt;
	logic        wr;

	assign pready   = 1'b1;
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign can_emit = !out_valid_q || !out_stall;
	assign full     = (count_q == FULL_CNT);
	assign head_exp = (count_q != '0) && (c_dl[0] <= now_q);
	assign pd_future = (pd_q != 64'd0) && (now_q < pd_q);
	assign qsum     = {1'b0, now_q} + {33'd0, quantum_q};
	assign qsat     = qsum[64] ? '1 : qsum[63:0];
	assign arm_tgt  = idle_q ? c_dl[0] :
	                  ((count_q != '0) && (c_dl[0] < qsat)) ? c_dl[0] : qsat;

	// wait chain: each cell decides on its own compare and its left neighbour's
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		localparam int L = (i == 0) ? 0 : i - 1;
		localparam int R = (i == TABLE_DEPTH - 1) ? i : i + 1;
		tdtq_cell #(.ID_W(ID_WIDTH)) u_cell (
			.clk       (clk),
			.op        (op),
			.valid     (count_q > CW'(i)),
			.new_dl    (dl_q),
			.new_id    (wid_q),
			.left_keep ((i == 0) ? 1'b1 : c_keep[L]),
			.left_dl   (c_dl[L]),
			.left_id   (c_id[L]),
			.right_dl  (c_dl[R]),
			.right_id  (c_id[R]),
			.keep      (c_keep[i]),
			.dl        (c_dl[i]),
			.id        (c_id[i])
		);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_acc) state_d = ST_DISP;
			ST_DISP: begin
				unique case (act_q)
					ACT_IRQ: begin
						if (!en_q) begin
							if (can_emit) state_d = ST_IDLE;
						end else if (pd_future) begin
							state_d = ST_MIN;
						end else begin
							state_d = ST_WAKE;
						end
					end
					ACT_ARM: state_d = ST_ARM;
					default: if (can_emit) state_d = ST_IDLE;
				endcase
			end
			ST_WAKE: begin
				if (!head_exp) begin
					if ((idle_q && ready_q) || (!idle_q && now_q >= qd_q)) begin
						if (can_emit) state_d = ST_IDLE;
					end else begin
						state_d = ST_ARM;
					end
				end
			end
			ST_ARM: begin
				if (idle_q && count_q == '0) begin
					if (can_emit) state_d = ST_IDLE;
				end else begin
					state_d = ST_DELTA;
				end
			end
			ST_DELTA: state_d = ST_MIN;
			ST_MIN:   state_d = ST_MAX;
			ST_MAX:   if (can_emit) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		emit    = 1'b0;
		e_kind  = KIND_ACK;
		e_id    = '0;
		e_delta = '0;
		e_pre   = 1'b0;
		e_last  = 1'b1;
		op      = CELL_HOLD;
		unique case (state_q)
			ST_DISP: begin
				unique case (act_q)
					ACT_INSERT: begin
						emit = can_emit;
						if (full) begin
							e_kind = KIND_FULL;
						end else if (can_emit) begin
							op = CELL_INS;
						end
					end
					ACT_IRQ:  emit = !en_q && can_emit;
					ACT_ARM:  ;
					default:  emit = can_emit;
				endcase
			end
			ST_WAKE: begin
				if (head_exp) begin
					emit   = can_emit;
					e_kind = KIND_WOKEN;
					e_id   = c_id[0];
					e_last = 1'b0;
					if (can_emit) op = CELL_POP;
				end else if (idle_q && ready_q) begin
					emit   = can_emit;
					e_kind = KIND_RESCH;
				end else if (!idle_q && now_q >= qd_q) begin
					emit   = can_emit;
					e_kind = KIND_RESCH;
					e_pre  = 1'b1;
				end
			end
			ST_ARM: emit = idle_q && (count_q == '0) && can_emit;
			ST_MAX: begin
				emit    = can_emit;
				e_kind  = KIND_ARM;
				e_delta = ((max_q != '0) && (dlt_q > {16'd0, max_q})) ? {16'd0, max_q} : dlt_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			pd_q        <= '0;
			qd_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (op == CELL_INS) count_q <= count_q + CW'(1);
			if (op == CELL_POP) count_q <= count_q - CW'(1);
			if (state_q == ST_ARM) begin
				if (idle_q && count_q == '0) begin
					pd_q <= '0;
				end else begin
					pd_q <= arm_tgt;
				end
				if (!idle_q) qd_q <= qsat;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_q   <= action_t'(action);
			now_q   <= now_ns;
			dl_q    <= deadline_ns;
			wid_q   <= wait_id;
			idle_q  <= thread_is_idle;
			ready_q <= ready_waiting;
		end
		if (state_q == ST_ARM) tgt_q <= arm_tgt;
		unique case (state_q)
			ST_DISP:  dlt_q <= pd_q - now_q;
			ST_DELTA: dlt_q <= (tgt_q > now_q) ? tgt_q - now_q : 64'd1;
			ST_MIN:   if ((min_q != '0) && (dlt_q < {32'd0, min_q})) dlt_q <= {32'd0, min_q};
			default:  ;
		endcase
		if (emit) begin
			kind_q  <= e_kind;
			woken_q <= e_id;
			delta_q <= e_delta;
			pre_q   <= e_pre;
			last_q  <= e_last;
		end
	end

	// configuration port, registers at 8-byte spacing
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q      <= 1'b0;
			quantum_q <= QUANTUM_RST;
			min_q     <= '0;
			max_q     <= '0;
		end else if (wr) begin
			unique case (paddr[4:3])
				REG_ENABLE:  en_q      <= pwdata[0];
				REG_QUANTUM: quantum_q <= pwdata[31:0];
				REG_MIN:     min_q     <= pwdata[31:0];
				REG_MAX:     max_q     <= pwdata[47:0];
				default:     ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:3])
			REG_ENABLE:  prdata = {63'd0, en_q};
			REG_QUANTUM: prdata = {32'd0, quantum_q};
			REG_MIN:     prdata = {32'd0, min_q};
			REG_MAX:     prdata = {16'd0, max_q};
			default:     prdata = '0;
		endcase
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign woken_id  = woken_q;
	assign delta_ns  = delta_q;
	assign preempt   = pre_q;
	assign last      = last_q;
endmodule

// ----- sv/tdtq_cell.sv -----
// One slot of the sorted wait chain.
module tdtq_cell import tdtq_pkg::*; #(
	parameter int ID_W = ID_WIDTH_DEF
) (
	input  logic            clk,
	input  cell_op_t        op,
	input  logic            valid,
	input  logic [63:0]     new_dl,
	input  logic [ID_W-1:0] new_id,
	input  logic            left_keep,
	input  logic [63:0]     left_dl,
	input  logic [ID_W-1:0] left_id,
	input  logic [63:0]     right_dl,
	input  logic [ID_W-1:0] right_id,
	output logic            keep,
	output logic [63:0]     dl,
	output logic [ID_W-1:0] id
);
	logic [63:0]     dl_q;
	logic [ID_W-1:0] id_q;

	// entry stays put when it sorts at or before the new deadline
	assign keep = valid && (dl_q <= new_dl);
	assign dl   = dl_q;
	assign id   = id_q;

	always_ff @(posedge clk) begin
		unique case (op)
			CELL_INS: begin
				if (!keep) begin
					if (left_keep) begin
						dl_q <= new_dl;
						id_q <= new_id;
					end else begin
						dl_q <= left_dl;
						id_q <= left_id;
					end
				end
			end
			CELL_POP: begin
				dl_q <= right_dl;
				id_q <= right_id;
			end
			default: ;
		endcase
	end
endmodule

// ----- sv/tdtq_checker.sv -----
// Port-level checks of the timer queue result channel, bound to the top level.
module tdtq_assertions import tdtq_pkg::*; #(
	parameter int ID_WIDTH = ID_WIDTH_DEF
) (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_stall,
	input logic [2:0]          kind,
	input logic [ID_WIDTH-1:0] woken_id,
	input logic [63:0]         delta_ns,
	input logic                preempt,
	input logic                last
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(delta_ns))
		else $error("stalled result changed");

	a_wake_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_WOKEN |-> !last)
		else $error("wake-up flagged as final result");

	a_arm_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_ARM |-> delta_ns != 64'd0 && woken_id == '0)
		else $error("zero arm delta");

	a_preempt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && preempt |-> kind == KIND_RESCH && last)
		else $error("preempt outside reschedule");
endmodule

bind tickless_deadline_timer_queue_core tdtq_assertions #(.ID_WIDTH(ID_WIDTH)) u_tdtq_assertions (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.kind      (kind),
	.woken_id  (woken_id),
	.delta_ns  (delta_ns),
	.preempt   (preempt),
	.last      (last)
);

// ----- tb/sv/tdtq_checker.sv -----
// Result checker for the deadline timer queue: mirrors the table and compares every result.
module tdtq_checker import tdtq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  action,
	input  logic [63:0] now_ns,
	input  logic [63:0] deadline_ns,
	input  logic [7:0]  wait_id,
	input  logic        thread_is_idle,
	input  logic        ready_waiting,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  kind,
	input  logic [7:0]  woken_id,
	input  logic [63:0] delta_ns,
	input  logic        preempt,
	input  logic        last,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 16;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  id;
		logic [63:0] delta;
		logic        pre;
		logic        fin;
	} tq_result_t;

	tq_result_t  due_q[$];
	logic [63:0] dl_tab[DEPTH];
	logic [7:0]  id_tab[DEPTH];
	int          n_entries;
	logic [63:0] prog_dl, quant_dl;
	logic        en_r;
	logic [31:0] quant_r, min_r;
	logic [47:0] max_r;

	assign pending = due_q.size();

	function automatic logic [63:0] clamp(input logic [63:0] d);
		if (min_r != 0 && d < min_r) d = min_r;
		if (max_r != 0 && d > max_r) d = max_r;
		return d;
	endfunction

	function automatic void push(input kind_t k, input logic [7:0] id, input logic [63:0] d,
		input logic p);
		tq_result_t r;
		r.kind = k; r.id = id; r.delta = d; r.pre = p; r.fin = 1'b0;
		due_q.push_back(r);
	endfunction

	function automatic void arm_timer(input logic [63:0] now, input logic idle);
		logic [63:0] tgt;
		if (idle) begin
			if (n_entries == 0) begin
				prog_dl = 0;
				push(KIND_ACK, 0, 0, 0);
				return;
			end
			tgt = dl_tab[0];
		end else begin
			quant_dl = (now > 64'hFFFF_FFFF_FFFF_FFFF - quant_r) ? '1 : now + quant_r;
			tgt = quant_dl;
			if (n_entries != 0 && dl_tab[0] < tgt) tgt = dl_tab[0];
		end
		prog_dl = tgt;
		push(KIND_ARM, 0, clamp(tgt > now ? tgt - now : 64'd1), 0);
	endfunction

	function automatic void predict_step(input action_t act, input logic [63:0] now,
		input logic [63:0] dl, input logic [7:0] wid, input logic idle, input logic rdy);
		int pos;
		tq_result_t r;
		case (act)
			ACT_INSERT: begin
				if (n_entries >= DEPTH) push(KIND_FULL, 0, 0, 0);
				else begin
					pos = 0;
					while (pos < n_entries && dl_tab[pos] <= dl) pos++;
					for (int i = n_entries; i > pos; i--) begin
						dl_tab[i] = dl_tab[i-1];
						id_tab[i] = id_tab[i-1];
					end
					dl_tab[pos] = dl;
					id_tab[pos] = wid;
					n_entries++;
					push(KIND_ACK, 0, 0, 0);
				end
			end
			ACT_IRQ: begin
				if (!en_r) push(KIND_ACK, 0, 0, 0);
				else if (prog_dl != 0 && now < prog_dl) push(KIND_ARM, 0, clamp(prog_dl - now), 0);
				else begin
					while (n_entries != 0 && dl_tab[0] <= now) begin
						push(KIND_WOKEN, id_tab[0], 0, 0);
						for (int i = 1; i < n_entries; i++) begin
							dl_tab[i-1] = dl_tab[i];
							id_tab[i-1] = id_tab[i];
						end
						n_entries--;
					end
					if (idle && rdy) push(KIND_RESCH, 0, 0, 0);
					else if (!idle && now >= quant_dl) push(KIND_RESCH, 0, 0, 1);
					else arm_timer(now, idle);
				end
			end
			ACT_ARM: arm_timer(now, idle);
			default: push(KIND_ACK, 0, 0, 0);
		endcase
		r = due_q[$];
		r.fin = 1'b1;
		due_q[$] = r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tq_result_t e;
		if (!arst_n) begin
			due_q.delete();
			n_entries = 0;
			prog_dl = 0;
			quant_dl = 0;
			en_r = 0;
			quant_r = QUANTUM_RST;
			min_r = 0;
			max_r = 0;
			fail_count = 0;
		end else begin
			// results first: a transaction in flight cannot yield in the same edge it is taken
			if (out_valid && !out_stall) begin
				if (due_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) $display("unexpected result kind=%0d", kind);
				end else begin
					e = due_q.pop_front();
					if (kind !== e.kind || woken_id !== e.id || delta_ns !== e.delta ||
						preempt !== e.pre || last !== e.fin) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: exp k=%0d id=%0d d=%0d p=%b l=%b got k=%0d id=%0d d=%0d p=%b l=%b",
								e.kind, e.id, e.delta, e.pre, e.fin,
								kind, woken_id, delta_ns, preempt, last);
					end
				end
			end
			if (psel && penable && pwrite) begin
				case (paddr[4:3])
					REG_ENABLE:  en_r = pwdata[0];
					REG_QUANTUM: quant_r = pwdata[31:0];
					REG_MIN:     min_r = pwdata[31:0];
					REG_MAX:     max_r = pwdata[47:0];
				endcase
			end
			if (in_valid && !in_stall)
				predict_step(action_t'(action), now_ns, deadline_ns, wait_id, thread_is_idle,
					ready_waiting);
		end
	end
endmodule

// ----- tb/sv/tb_top.sv -----
// Stimulus and verdict for the deadline timer queue testbench.
module tb_top import tdtq_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;

	logic        clk = 0, arst_n = 0;
	logic        psel = 0, penable = 0, pwrite = 0;
	logic [4:0]  paddr = 0;
	logic [63:0] pwdata = 0, prdata;
	logic        pready;
	logic        in_valid = 0, in_stall;
	logic [1:0]  action = 0;
	logic [63:0] now_ns = 0, deadline_ns = 0;
	logic [7:0]  wait_id = 0;
	logic        thread_is_idle = 0, ready_waiting = 0;
	logic        out_valid, out_stall = 0;
	logic [2:0]  kind;
	logic [7:0]  woken_id;
	logic [63:0] delta_ns;
	logic        preempt, last;
	int          fail_count, pending;
	int          cycles = 0;
	logic        hold_off = 0;   // long receiver stall requested by the stimulus

	// simulated uptime, moves forward mostly so that waits really expire
	logic [63:0] uptime = 64'd1000;

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	tickless_deadline_timer_queue_core dut (.*);

	tdtq_checker chk (.*);

	// cycle watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// receiver: random stall per result, long stretch on request
	initial begin
		int gap;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_stall <= 1;
				repeat (300) @(posedge clk);
				out_stall <= 0;
				@(posedge clk);
			end
			if (out_valid && !out_stall) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
				if (gap != 0) begin
					out_stall <= 1;
					repeat (gap) @(posedge clk);
					out_stall <= 0;
				end
			end
		end
	end

	task automatic reg_write(input logic [1:0] idx, input logic [63:0] val);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 3'b000}; pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	// one transaction on the input channel, with a random idle gap beforehand
	task automatic send(input action_t act, input logic [63:0] now, input logic [63:0] dl,
		input logic [7:0] id, input logic idle, input logic rdy, input bit nogap = 0);
		int gap;
		gap = nogap ? 0 : $urandom_range(0, 6);
		repeat (gap) @(posedge clk);
		in_valid <= 1; action <= act; now_ns <= now; deadline_ns <= dl;
		wait_id <= id; thread_is_idle <= idle; ready_waiting <= rdy;
		do @(posedge clk); while (in_stall);
		in_valid <= 0;
	endtask

	// quiet point between configuration phases; one edge first so the last
	// accepted transaction is already counted as pending
	task automatic drain();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [63:0] r64();
		return {$urandom(), $urandom()};
	endfunction

	initial begin
		action_t act;
		logic [63:0] dl;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// --- directed: reset configuration, scheduler off
		send(ACT_IRQ, 64'd5, 0, 0, 0, 0);
		send(ACT_ARM, 64'd5, 0, 0, 0, 0);
		send(ACT_ARM, 64'd5, 0, 0, 1, 0);          // idle, empty table: nothing armed
		send(ACT_NONE, '1, '1, 8'hFF, 1, 1);
		drain();
		reg_write(REG_ENABLE, 64'd1);
		reg_write(REG_QUANTUM, 64'hFFFF_FFFF);
		reg_write(REG_MIN, 64'd0);
		reg_write(REG_MAX, 64'd0);
		// fill the table past full, equal deadlines keep insertion order
		for (int i = 0; i < 17; i++)
			send(ACT_INSERT, 0, (i < 4) ? 64'd100 : ((i == 16) ? '1 : 64'd50 + i), i[7:0],
				0, 0);
		send(ACT_ARM, '1, 0, 0, 0, 0);             // saturated quantum deadline
		send(ACT_IRQ, 64'd10, 0, 0, 0, 0);         // remainder re-arm
		send(ACT_IRQ, '1, 0, 0, 1, 1);             // wake everything, idle with work
		send(ACT_ARM, 64'd0, 0, 0, 0, 0);
		send(ACT_IRQ, 64'hFFFF_FFFF, 0, 0, 0, 0);  // quantum expiry
		send(ACT_INSERT, 0, 64'd3, 8'hAA, 0, 0);
		send(ACT_ARM, 64'd9, 0, 0, 1, 0);          // target passed: delta 1
		drain();
		reg_write(REG_MIN, 64'hFFFF_FFFF);
		reg_write(REG_MAX, 64'd1000);              // min above max: max wins
		send(ACT_ARM, 64'd1, 0, 0, 1, 0);
		send(ACT_IRQ, 64'd2, 0, 0, 1, 0);
		drain();
		reg_write(REG_MAX, 64'hFFFF_FFFF_FFFF);
		reg_write(REG_MIN, 64'd1);
		reg_write(REG_QUANTUM, 64'd1);

		// --- random: phases with different settings
		for (int ph = 0; ph < 4; ph++) begin
			drain();
			case (ph)
				1: begin
					reg_write(REG_QUANTUM, $urandom_range(1, 5000));
					reg_write(REG_MIN, $urandom_range(0, 20));
					reg_write(REG_MAX, $urandom_range(0, 3000));
				end
				2: begin
					reg_write(REG_QUANTUM, $urandom());
					reg_write(REG_MIN, $urandom());
					reg_write(REG_MAX, {$urandom_range(0, 65535), $urandom()});
				end
				3: begin
					reg_write(REG_ENABLE, 64'd0);
					reg_write(REG_MAX, 64'd0);
				end
				default: ;
			endcase
			if (ph == 1) hold_off <= 1;
			for (int i = 0; i < 52; i++) begin
				if (ph == 1 && i == 1) hold_off <= 0;
				uptime = uptime + $urandom_range(0, 400);
				if (ph == 3 && i == 26) begin
					drain();
					reg_write(REG_ENABLE, 64'd1);
				end
				case ($urandom_range(0, 9))
					0, 1, 2, 3: act = ACT_INSERT;
					4, 5, 6:    act = ACT_IRQ;
					7, 8:       act = ACT_ARM;
					default:    act = ACT_NONE;
				endcase
				dl = ($urandom_range(0, 15) == 0) ? r64() : uptime + $urandom_range(0, 1500);
				if ($urandom_range(0, 20) == 0) uptime = r64();
				send(act, uptime, dl, $urandom_range(0, 255), $urandom_range(0, 1),
					$urandom_range(0, 1), ph == 1 && i < 20);
			end
		end

		drain();
		if (fail_count == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end
endmodule
